// File: sv/lkws_pkg.sv
// Shared types and constants for the Lucas-Kanade window solver.
// Depends on nothing; the front end, queue, solver and core import it.
package lkws_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd1920;
    localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd1080;

    typedef struct packed {
        logic        [26:0] xx;
        logic signed [27:0] xy;
        logic        [26:0] yy;
        logic signed [27:0] xt;
        logic signed [27:0] yt;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic               too_many;
    } window_t;

endpackage

// File: sv/lkws_ifs.sv
// Request channels of the window solver: gradient samples in, flow results out.
// Depends on nothing.
interface lkws_in_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] grad_x;
    logic signed [10:0] grad_y;
    logic signed [10:0] grad_t;
    logic               last_sample;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;

    modport source (output valid, grad_x, grad_y, grad_t, last_sample, pos_x, pos_y,
                    input ready);
    modport sink   (input valid, grad_x, grad_y, grad_t, last_sample, pos_x, pos_y,
                    output ready);
endinterface

interface lkws_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] flow_x;
    logic signed [31:0] flow_y;
    logic        [23:0] pixel_index;
    logic        [1:0]  status;

    modport source (output valid, flow_x, flow_y, pixel_index, status, input ready);
    modport sink   (input valid, flow_x, flow_y, pixel_index, status, output ready);
endinterface

// File: sv/lkws_front.sv
// Front end: accepts gradient samples and accumulates the window sums.
// Depends on lkws_pkg and lkws_ifs; pushes one window record per last sample.
module lkws_front #(
    parameter int MAX_WINDOW_SAMPLES = 64,
    parameter int GRADIENT_BITS      = 11
) (
    input  logic            clk,
    input  logic            rst_n,
    lkws_in_if.sink         sample,
    output lkws_pkg::window_t win,
    output logic            win_valid,
    input  logic            win_ready
);
    import lkws_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW_SAMPLES + 2);
    localparam int GB = GRADIENT_BITS;

    logic        [26:0] acc_xx_reg, acc_xx_next;
    logic signed [27:0] acc_xy_reg, acc_xy_next;
    logic        [26:0] acc_yy_reg, acc_yy_next;
    logic signed [27:0] acc_xt_reg, acc_xt_next;
    logic signed [27:0] acc_yt_reg, acc_yt_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [15:0]        raw_x, raw_y, raw_t;
    logic signed [16:0] gx, gy, gt;
    logic signed [33:0] pxx, pxy, pyy, pxt, pyt;
    logic               accept, room;

    assign sample.ready = win_ready;
    assign accept = sample.valid && sample.ready;

    assign raw_x = {5'd0, sample.grad_x};
    assign raw_y = {5'd0, sample.grad_y};
    assign raw_t = {5'd0, sample.grad_t};
    assign gx = signed'({{(17 - GB){raw_x[GB-1]}}, raw_x[GB-1:0]});
    assign gy = signed'({{(17 - GB){raw_y[GB-1]}}, raw_y[GB-1:0]});
    assign gt = signed'({{(17 - GB){raw_t[GB-1]}}, raw_t[GB-1:0]});

    assign pxx = gx * gx;
    assign pxy = gx * gy;
    assign pyy = gy * gy;
    assign pxt = gx * gt;
    assign pyt = gy * gt;

    assign room = count_reg < CW'(MAX_WINDOW_SAMPLES);

    always_comb
    begin
        acc_xx_next = acc_xx_reg;
        acc_xy_next = acc_xy_reg;
        acc_yy_next = acc_yy_reg;
        acc_xt_next = acc_xt_reg;
        acc_yt_next = acc_yt_reg;
        count_next  = CW'(MAX_WINDOW_SAMPLES + 1);
        if (room)
        begin
            acc_xx_next = acc_xx_reg + pxx[26:0];
            acc_xy_next = acc_xy_reg + pxy[27:0];
            acc_yy_next = acc_yy_reg + pyy[26:0];
            acc_xt_next = acc_xt_reg + pxt[27:0];
            acc_yt_next = acc_yt_reg + pyt[27:0];
            count_next  = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        win.xx       = acc_xx_next;
        win.xy       = acc_xy_next;
        win.yy       = acc_yy_next;
        win.xt       = acc_xt_next;
        win.yt       = acc_yt_next;
        win.pos_x    = sample.pos_x;
        win.pos_y    = sample.pos_y;
        win.too_many = !room;
    end

    assign win_valid = accept && sample.last_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_xx_reg <= '0;
            acc_xy_reg <= '0;
            acc_yy_reg <= '0;
            acc_xt_reg <= '0;
            acc_yt_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            if (sample.last_sample)
            begin
                acc_xx_reg <= '0;
                acc_xy_reg <= '0;
                acc_yy_reg <= '0;
                acc_xt_reg <= '0;
                acc_yt_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                acc_xx_reg <= acc_xx_next;
                acc_xy_reg <= acc_xy_next;
                acc_yy_reg <= acc_yy_next;
                acc_xt_reg <= acc_xt_next;
                acc_yt_reg <= acc_yt_next;
                count_reg  <= count_next;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOW_SAMPLES + 1))
        else $error("sample count beyond saturation");

endmodule

// File: sv/lkws_queue.sv
// Two-entry queue of finished window records between front end and solver.
// Depends on lkws_pkg.
module lkws_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  lkws_pkg::window_t push_data,
    input  logic              push_valid,
    output logic              push_ready,
    output lkws_pkg::window_t pop_data,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import lkws_pkg::*;

    window_t     mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = mem[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue fill count corrupt");

endmodule

// File: sv/lkws_solver.sv
// Back end: solves the 2x2 system by Cramer's rule with a bit-serial divider.
// Depends on lkws_pkg and lkws_ifs; drives the result channel from registers.
module lkws_solver (
    input  logic              clk,
    input  logic              rst_n,
    input  lkws_pkg::window_t win,
    input  logic              win_valid,
    output logic              win_ready,
    input  logic [12:0]       frame_width,
    input  logic [12:0]       frame_height,
    lkws_out_if.source        result
);
    import lkws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIFF,
        S_PREP,
        S_DIV,
        S_RND,
        S_HOLD
    } state_t;

    localparam int QB = 33;

    state_t             state_reg;
    window_t            win_reg;
    logic signed [55:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    logic signed [56:0] det_reg, nx_reg, ny_reg;
    logic        [56:0] d_reg, rx_reg, ry_reg;
    logic        [QB-1:0] nbx_reg, nby_reg, qx_reg, qy_reg;
    logic               negx_reg, negy_reg, ovfx_reg, ovfy_reg;
    logic        [5:0]  cnt_reg;
    logic        [23:0] idx_reg;

    logic signed [27:0] s_xx, s_yy;
    logic signed [56:0] det_c, nx_c, ny_c;
    logic               outside;
    logic        [25:0] row_prod;
    logic        [25:0] idx_sum;
    logic        [56:0] dm, nxm, nym;
    logic        [72:0] dshift;
    logic        [57:0] rsx, rsy, rnx, rny;
    logic               gex, gey;
    logic        [33:0] sumx, sumy;
    logic        [32:0] magx, magy;

    function automatic logic [31:0] saturate(input logic neg, input logic [32:0] mag);
        logic [31:0] res;
        if (neg)
        begin
            res = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
        end
        else
        begin
            res = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction

    assign win_ready = state_reg == S_IDLE;

    assign s_xx = signed'({1'b0, win_reg.xx});
    assign s_yy = signed'({1'b0, win_reg.yy});

    assign det_c = {p_a_reg[55], p_a_reg} - {p_b_reg[55], p_b_reg};
    assign nx_c  = {p_c_reg[55], p_c_reg} - {p_d_reg[55], p_d_reg};
    assign ny_c  = {p_e_reg[55], p_e_reg} - {p_f_reg[55], p_f_reg};

    assign outside = win_reg.pos_x[12] || win_reg.pos_y[12]
                  || ({1'b0, win_reg.pos_x[11:0]} >= frame_width)
                  || ({1'b0, win_reg.pos_y[11:0]} >= frame_height);
    assign row_prod = 26'(win_reg.pos_y[12:0]) * 26'(frame_width);
    assign idx_sum  = row_prod + 26'(win_reg.pos_x[12:0]);

    assign dm  = det_reg[56] ? 57'(-det_reg) : 57'(det_reg);
    assign nxm = nx_reg[56] ? 57'(-nx_reg) : 57'(nx_reg);
    assign nym = ny_reg[56] ? 57'(-ny_reg) : 57'(ny_reg);
    assign dshift = {dm, 16'd0};

    assign rsx = {rx_reg, nbx_reg[QB-1]};
    assign rsy = {ry_reg, nby_reg[QB-1]};
    assign gex = rsx >= {1'b0, d_reg};
    assign gey = rsy >= {1'b0, d_reg};
    assign rnx = gex ? rsx - {1'b0, d_reg} : rsx;
    assign rny = gey ? rsy - {1'b0, d_reg} : rsy;

    assign sumx = {1'b0, qx_reg} + 34'd1;
    assign sumy = {1'b0, qy_reg} + 34'd1;
    assign magx = ovfx_reg ? 33'h1_0000_0000 : sumx[33:1];
    assign magy = ovfy_reg ? 33'h1_0000_0000 : sumy[33:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            result.valid       <= 1'b0;
            result.flow_x      <= '0;
            result.flow_y      <= '0;
            result.pixel_index <= '0;
            result.status      <= ST_OK;
            win_reg            <= '0;
            p_a_reg            <= '0;
            p_b_reg            <= '0;
            p_c_reg            <= '0;
            p_d_reg            <= '0;
            p_e_reg            <= '0;
            p_f_reg            <= '0;
            det_reg            <= '0;
            nx_reg             <= '0;
            ny_reg             <= '0;
            d_reg              <= '0;
            rx_reg             <= '0;
            ry_reg             <= '0;
            nbx_reg            <= '0;
            nby_reg            <= '0;
            qx_reg             <= '0;
            qy_reg             <= '0;
            negx_reg           <= 1'b0;
            negy_reg           <= 1'b0;
            ovfx_reg           <= 1'b0;
            ovfy_reg           <= 1'b0;
            cnt_reg            <= '0;
            idx_reg            <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (win_valid)
                    begin
                        win_reg   <= win;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    p_a_reg   <= s_xx * s_yy;
                    p_b_reg   <= win_reg.xy * win_reg.xy;
                    p_c_reg   <= win_reg.xy * win_reg.yt;
                    p_d_reg   <= s_yy * win_reg.xt;
                    p_e_reg   <= win_reg.xy * win_reg.xt;
                    p_f_reg   <= s_xx * win_reg.yt;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    det_reg <= det_c;
                    nx_reg  <= nx_c;
                    ny_reg  <= ny_c;
                    idx_reg <= idx_sum[23:0];
                    priority if (win_reg.too_many)
                    begin
                        result.status <= ST_OVERFLOW;
                    end
                    else if (det_c == '0)
                    begin
                        result.status <= ST_SINGULAR;
                    end
                    else if (outside)
                    begin
                        result.status <= ST_OUTSIDE;
                    end
                    else
                    begin
                        result.status <= ST_OK;
                    end
                    if (win_reg.too_many || det_c == '0 || outside)
                    begin
                        result.flow_x      <= '0;
                        result.flow_y      <= '0;
                        result.pixel_index <= '0;
                        result.valid       <= 1'b1;
                        state_reg          <= S_HOLD;
                    end
                    else
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    d_reg     <= dm;
                    rx_reg    <= 57'(nxm >> 16);
                    ry_reg    <= 57'(nym >> 16);
                    nbx_reg   <= {nxm[15:0], 17'd0};
                    nby_reg   <= {nym[15:0], 17'd0};
                    qx_reg    <= '0;
                    qy_reg    <= '0;
                    negx_reg  <= nx_reg[56] != det_reg[56];
                    negy_reg  <= ny_reg[56] != det_reg[56];
                    ovfx_reg  <= {16'd0, nxm} >= dshift;
                    ovfy_reg  <= {16'd0, nym} >= dshift;
                    cnt_reg   <= 6'(QB);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rx_reg  <= rnx[56:0];
                    ry_reg  <= rny[56:0];
                    nbx_reg <= {nbx_reg[QB-2:0], 1'b0};
                    nby_reg <= {nby_reg[QB-2:0], 1'b0};
                    qx_reg  <= {qx_reg[QB-2:0], gex};
                    qy_reg  <= {qy_reg[QB-2:0], gey};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    result.flow_x      <= signed'(saturate(negx_reg, magx));
                    result.flow_y      <= signed'(saturate(negy_reg, magy));
                    result.pixel_index <= idx_reg;
                    result.valid       <= 1'b1;
                    state_reg          <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (result.ready)
                    begin
                        result.valid <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_zero_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_OK
        |-> result.flow_x == 0 && result.flow_y == 0 && result.pixel_index == 0)
        else $error("fields not cleared on failed solve");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> state_reg == S_DIV || state_reg == S_RND)
        else $error("divider left early");

    a_rnd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RND |=> result.valid)
        else $error("rounded result not presented");

endmodule

// File: sv/lucas_kanade_window_solver_core.sv
// Records pass through the queue to the solver: MUL, DIFF, PREP, the 33-step serial
// divider, RND; a status that is not ok goes from DIFF to the result. Samples enter
// one per cycle while the queue has room; a window can accumulate during a solve.
// Reset clears accumulators, queue and solver; frame size returns to 1920x1080.
module lucas_kanade_window_solver_core #(
    parameter int MAX_WINDOW_SAMPLES = 64,
    parameter int GRADIENT_BITS      = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    lkws_in_if.sink     sample,
    lkws_out_if.source  result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import lkws_pkg::*;

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    window_t     front_win;
    logic        front_valid, front_ready;
    window_t     back_win;
    logic        back_valid, back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    lkws_front #(
        .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES),
        .GRADIENT_BITS      (GRADIENT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .win       (front_win),
        .win_valid (front_valid),
        .win_ready (front_ready)
    );

    lkws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_win),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_win),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    lkws_solver u_solver (
        .clk          (clk),
        .rst_n        (rst_n),
        .win          (back_win),
        .win_valid    (back_valid),
        .win_ready    (back_ready),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .result       (result)
    );

endmodule
